FILE: rtl/core/rhw_pkg.sv
// Package for the rolling-hash winnowing unit.
// Holds field and register types, reset values and the mod 2^31-1 reduction.
// No dependencies.
`default_nettype none

package rhw_pkg;

   typedef logic [7:0]  char_type;
   typedef logic [30:0] hash_type;
   typedef logic [23:0] pos_type;
   typedef logic [30:0] csr_data_type;

   typedef enum logic [1:0] {
      CSR_GRAM_LENGTH    = 2'd0,
      CSR_HASH_BASE      = 2'd1,
      CSR_WINDOW_SIZE    = 2'd2,
      CSR_LEADING_WEIGHT = 2'd3
   } csr_index_type;

   localparam hash_type PRIME_P = 31'h7FFF_FFFF;
   localparam pos_type  POS_MAX = 24'hFF_FFFF;

   localparam logic [5:0]  RST_GRAM_LENGTH    = 6'd10;
   localparam logic [7:0]  RST_HASH_BASE      = 8'd19;
   localparam logic [5:0]  RST_WINDOW_SIZE    = 6'd15;
   localparam logic [30:0] RST_LEADING_WEIGHT = 31'd565150729;

   // Fold a product below 2^40 twice into 31 bits, then one conditional subtract.
   function automatic hash_type mod_p(input logic [39:0] d);
      logic [31:0] f1;
      logic [31:0] f2;
      f1 = {1'b0, d[30:0]} + {23'b0, d[39:31]};
      f2 = {1'b0, f1[30:0]} + {31'b0, f1[31]};
      if (f2 >= {1'b0, PRIME_P}) begin
         f2 = f2 - {1'b0, PRIME_P};
      end
      return f2[30:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rolling_hash_winnowing_unit.sv
// Rolling-hash winnowing unit: top level.
// Byte ring and hash ring in local synchronous memories; uses rhw_pkg.
// Usage:
//   Request channel (req_*): one document byte per transfer, with req_doc_start
//   set on the first byte of a document. Result channel (rsp_*): one
//   (fingerprint hash, gram position) per change of the selected minimum.
//   Configuration (csr_*): write gram length, hash base, window size and the
//   leading weight base^(k-1) mod 2^31-1 while the unit is idle.
// Timing:
//   One byte at a time; a byte goes through, before the next transfer, the
//   leaving-byte read in the transfer cycle and two multiply/reduce pairs
//   through a single multiply path each. A byte that completes a gram adds
//   a decision state, and one that selects a new gram adds an emit state to
//   load the result register, which waits while an earlier result is
//   stalled. With no selected minimum yet, or when the selected minimum
//   leaves the window, the hash ring is rescanned through its single read
//   port, one entry a cycle.
// Reset: synchronous; the unit comes up idle with the register defaults
//   and no document in progress. Ring contents are left unwritten.
// Stall: a result waits in the output register while rsp_stall is high; the
//   next byte is still taken and only a further result waits behind it.
`default_nettype none

module rolling_hash_winnowing_unit #(
   parameter int GRAM_MAX   = 32,
   parameter int WINDOW_MAX = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  rhw_pkg::char_type     req_char_in,
   input  wire                   req_doc_start,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output rhw_pkg::hash_type     rsp_fingerprint_hash,
   output rhw_pkg::pos_type      rsp_gram_position,
   input  wire                   csr_we,
   input  rhw_pkg::csr_index_type csr_index,
   input  rhw_pkg::csr_data_type csr_wdata
);
   import rhw_pkg::*;

   localparam int GA = $clog2(GRAM_MAX);
   localparam int HA = $clog2(WINDOW_MAX);
   localparam int KW = $clog2(GRAM_MAX + 1);
   localparam int WW = $clog2(WINDOW_MAX + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL1,
      S_RED1,
      S_MUL2,
      S_RED2,
      S_DECIDE,
      S_SCAN,
      S_EMIT
   } state_type;

   // configuration
   logic [5:0]  gram_length_ff, gram_length_in;
   logic [7:0]  hash_base_ff, hash_base_in;
   logic [5:0]  window_size_ff, window_size_in;
   logic [30:0] leading_weight_ff, leading_weight_in;

   // control
   state_type       state_ff, state_in;
   pos_type         byte_count_ff, byte_count_in;
   logic [GA-1:0]   gptr_ff, gptr_in;
   // byte count modulo the hash ring depth
   logic [HA-1:0]   hptr_ff, hptr_in;
   hash_type        running_hash_ff, running_hash_in;
   hash_type        min_hash_ff, min_hash_in;
   pos_type         min_pos_ff, min_pos_in;
   logic            min_valid_ff, min_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]   issue_left_ff, issue_left_in;
   logic [WW-1:0]   cmp_left_ff, cmp_left_in;
   logic            rvalid_ff, rvalid_in;
   logic            best_seen_ff, best_seen_in;

   // datapath
   char_type        char_ff, char_in;
   logic [39:0]     prod_ff, prod_in;
   hash_type        sub_ff, sub_in;
   hash_type        h_ff, h_in;
   pos_type         g_ff, g_in;
   logic [HA-1:0]   hidx_ff, hidx_in;
   logic [HA-1:0]   rd_idx_ff, rd_idx_in;
   hash_type        best_ff, best_in;
   pos_type         best_pos_ff, best_pos_in;
   pos_type         cmp_pos_ff, cmp_pos_in;
   hash_type        rsp_hash_ff, rsp_hash_in;
   pos_type         rsp_pos_ff, rsp_pos_in;

   // memories
   char_type        gram_mem [GRAM_MAX];
   hash_type        hash_mem [WINDOW_MAX];
   logic            gram_we;
   logic [GA-1:0]   gram_raddr;
   char_type        gram_q_ff;
   logic            hash_we;
   hash_type        hash_wdata;
   logic [HA-1:0]   hash_raddr;
   hash_type        hash_q_ff;

   // helpers
   logic [KW-1:0]   k_eff;
   logic [WW-1:0]   w_eff;
   logic [31:0]     k_wide;
   logic [31:0]     w_wide;
   hash_type        lw_red;
   logic            req_xfer;
   logic            saturated;
   logic [31:0]     leave_wide;
   char_type        leave_byte;
   logic [38:0]     mul1;
   hash_type        diff;
   logic [31:0]     diff_wrap;
   logic [39:0]     mul2;
   hash_type        h_red;
   logic [24:0]     n_plus1;
   logic [24:0]     g_plus1;
   logic [24:0]     min_end;
   logic [31:0]     scan_start;
   logic            take_new;
   hash_type        best_sel;
   pos_type         best_pos_sel;
   logic [HA-1:0]   hptr_next;
   logic [HA-1:0]   kmod;
   logic [31:0]     hwr_wide;
   logic [HA-1:0]   hwr_idx;

   // gram length modulo the hash ring depth, as a small constant table
   function automatic logic [HA-1:0] gram_mod_window(input logic [KW-1:0] k);
      logic [HA-1:0] r;
      r = '0;
      for (int i = 1; i <= GRAM_MAX; i++) begin
         if (k == KW'(i)) begin
            r = HA'(i % WINDOW_MAX);
         end
      end
      return r;
   endfunction

   // clamp lengths: zero acts as one, values past the ring depth act as the depth
   always_comb begin
      if (gram_length_ff == 6'd0) begin
         k_wide = 32'd1;
      end else if (32'(gram_length_ff) > 32'(GRAM_MAX)) begin
         k_wide = 32'(GRAM_MAX);
      end else begin
         k_wide = 32'(gram_length_ff);
      end
      if (window_size_ff == 6'd0) begin
         w_wide = 32'd1;
      end else if (32'(window_size_ff) > 32'(WINDOW_MAX)) begin
         w_wide = 32'(WINDOW_MAX);
      end else begin
         w_wide = 32'(window_size_ff);
      end
   end

   assign k_eff  = k_wide[KW-1:0];
   assign w_eff  = w_wide[WW-1:0];
   assign lw_red = (leading_weight_ff == PRIME_P) ? 31'd0 : leading_weight_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign saturated = !req_doc_start && (byte_count_ff == POS_MAX);

   // leaving byte sits k entries behind the write pointer
   assign leave_wide = 32'(gptr_ff) + 32'(GRAM_MAX) - 32'(k_eff);
   assign gram_raddr = (leave_wide >= 32'(GRAM_MAX)) ?
                       GA'(leave_wide - 32'(GRAM_MAX)) : GA'(leave_wide);
   assign leave_byte = (25'(byte_count_ff) >= 25'(k_eff)) ? gram_q_ff : 8'd0;
   assign mul1       = {31'b0, leave_byte} * {8'b0, lw_red};

   assign diff_wrap = {1'b0, running_hash_ff} + {1'b0, PRIME_P} - {1'b0, sub_ff};
   assign diff      = (running_hash_ff >= sub_ff) ? (running_hash_ff - sub_ff) :
                      diff_wrap[30:0];
   assign mul2      = {9'b0, diff} * {32'b0, hash_base_ff} + {32'b0, char_ff};
   assign h_red     = mod_p(prod_ff);

   assign n_plus1 = 25'(byte_count_ff) + 25'd1;
   assign g_plus1 = 25'(g_ff) + 25'd1;
   assign min_end = 25'(min_pos_ff) + 25'(w_eff);

   // hash slot of gram n+1-k: (n+1) mod depth minus k mod depth, wrapped
   assign hptr_next = (32'(hptr_ff) == 32'(WINDOW_MAX - 1)) ? '0 : hptr_ff + 1'b1;
   assign kmod      = gram_mod_window(k_eff);
   assign hwr_wide  = (hptr_next >= kmod) ? (32'(hptr_next) - 32'(kmod)) :
                      (32'(hptr_next) + 32'(WINDOW_MAX) - 32'(kmod));
   assign hwr_idx   = hwr_wide[HA-1:0];

   assign scan_start = (32'(hidx_ff) >= w_wide - 32'd1) ?
                       (32'(hidx_ff) - (w_wide - 32'd1)) :
                       (32'(hidx_ff) + 32'(WINDOW_MAX) - (w_wide - 32'd1));

   // rescan compare: ties go to the later gram
   assign take_new     = !best_seen_ff || (hash_q_ff <= best_ff);
   assign best_sel     = take_new ? hash_q_ff : best_ff;
   assign best_pos_sel = take_new ? cmp_pos_ff : best_pos_ff;

   assign hash_raddr = rd_idx_ff;
   assign hash_wdata = h_red;

   always_comb begin
      gram_length_in    = gram_length_ff;
      hash_base_in      = hash_base_ff;
      window_size_in    = window_size_ff;
      leading_weight_in = leading_weight_ff;
      state_in          = state_ff;
      byte_count_in     = byte_count_ff;
      gptr_in           = gptr_ff;
      hptr_in           = hptr_ff;
      running_hash_in   = running_hash_ff;
      min_hash_in       = min_hash_ff;
      min_pos_in        = min_pos_ff;
      min_valid_in      = min_valid_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      issue_left_in     = issue_left_ff;
      cmp_left_in       = cmp_left_ff;
      rvalid_in         = 1'b0;
      best_seen_in      = best_seen_ff;
      char_in           = char_ff;
      prod_in           = prod_ff;
      sub_in            = sub_ff;
      h_in              = h_ff;
      g_in              = g_ff;
      hidx_in           = hidx_ff;
      rd_idx_in         = rd_idx_ff;
      best_in           = best_ff;
      best_pos_in       = best_pos_ff;
      cmp_pos_in        = cmp_pos_ff;
      rsp_hash_in       = rsp_hash_ff;
      rsp_pos_in        = rsp_pos_ff;
      gram_we           = 1'b0;
      hash_we           = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_GRAM_LENGTH:    gram_length_in    = csr_wdata[5:0];
            CSR_HASH_BASE:      hash_base_in      = csr_wdata[7:0];
            CSR_WINDOW_SIZE:    window_size_in    = csr_wdata[5:0];
            CSR_LEADING_WEIGHT: leading_weight_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               char_in = req_char_in;
               if (req_doc_start) begin
                  byte_count_in   = '0;
                  gptr_in         = '0;
                  hptr_in         = '0;
                  running_hash_in = '0;
                  min_hash_in     = '0;
                  min_pos_in      = '0;
                  min_valid_in    = 1'b0;
               end
               // drop bytes once the position count is saturated
               if (!saturated) begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            prod_in  = {1'b0, mul1};
            gram_we  = 1'b1;
            state_in = S_RED1;
         end
         S_RED1: begin
            sub_in   = mod_p(prod_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in  = mul2;
            state_in = S_RED2;
         end
         S_RED2: begin
            h_in            = h_red;
            running_hash_in = h_red;
            byte_count_in   = n_plus1[23:0];
            gptr_in         = (32'(gptr_ff) == 32'(GRAM_MAX - 1)) ? '0 : gptr_ff + 1'b1;
            hptr_in         = hptr_next;
            if (n_plus1 >= 25'(k_eff)) begin
               hash_we  = 1'b1;
               hidx_in  = hwr_idx;
               g_in     = 24'(n_plus1 - 25'(k_eff));
               state_in = S_DECIDE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DECIDE: begin
            if (g_plus1 < 25'(w_eff)) begin
               state_in = S_IDLE;
            end else if (!min_valid_ff || (min_end <= 25'(g_ff))) begin
               rd_idx_in     = scan_start[HA-1:0];
               issue_left_in = w_eff;
               cmp_left_in   = w_eff;
               best_seen_in  = 1'b0;
               cmp_pos_in    = 24'(g_plus1 - 25'(w_eff));
               state_in      = S_SCAN;
            end else if (h_ff <= min_hash_ff) begin
               min_hash_in = h_ff;
               min_pos_in  = g_ff;
               state_in    = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            // issue one ring read a cycle, compare it the cycle after
            if (issue_left_ff != '0) begin
               issue_left_in = issue_left_ff - 1'b1;
               rvalid_in     = 1'b1;
               rd_idx_in     = (32'(rd_idx_ff) == 32'(WINDOW_MAX - 1)) ? '0 :
                               rd_idx_ff + 1'b1;
            end
            if (rvalid_ff) begin
               best_in      = best_sel;
               best_pos_in  = best_pos_sel;
               best_seen_in = 1'b1;
               cmp_pos_in   = cmp_pos_ff + 1'b1;
               cmp_left_in  = cmp_left_ff - 1'b1;
               if (cmp_left_ff == WW'(1)) begin
                  min_hash_in  = best_sel;
                  min_pos_in   = best_pos_sel;
                  min_valid_in = 1'b1;
                  state_in     = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = min_hash_ff;
               rsp_pos_in   = min_pos_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gram_length_ff    <= RST_GRAM_LENGTH;
         hash_base_ff      <= RST_HASH_BASE;
         window_size_ff    <= RST_WINDOW_SIZE;
         leading_weight_ff <= RST_LEADING_WEIGHT;
         state_ff          <= S_IDLE;
         byte_count_ff     <= '0;
         gptr_ff           <= '0;
         hptr_ff           <= '0;
         running_hash_ff   <= '0;
         min_hash_ff       <= '0;
         min_pos_ff        <= '0;
         min_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         issue_left_ff     <= '0;
         cmp_left_ff       <= '0;
         rvalid_ff         <= 1'b0;
         best_seen_ff      <= 1'b0;
      end else begin
         gram_length_ff    <= gram_length_in;
         hash_base_ff      <= hash_base_in;
         window_size_ff    <= window_size_in;
         leading_weight_ff <= leading_weight_in;
         state_ff          <= state_in;
         byte_count_ff     <= byte_count_in;
         gptr_ff           <= gptr_in;
         hptr_ff           <= hptr_in;
         running_hash_ff   <= running_hash_in;
         min_hash_ff       <= min_hash_in;
         min_pos_ff        <= min_pos_in;
         min_valid_ff      <= min_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         issue_left_ff     <= issue_left_in;
         cmp_left_ff       <= cmp_left_in;
         rvalid_ff         <= rvalid_in;
         best_seen_ff      <= best_seen_in;
      end
      char_ff     <= char_in;
      prod_ff     <= prod_in;
      sub_ff      <= sub_in;
      h_ff        <= h_in;
      g_ff        <= g_in;
      hidx_ff     <= hidx_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      cmp_pos_ff  <= cmp_pos_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (gram_we) begin
         gram_mem[gptr_ff] <= char_ff;
      end
      gram_q_ff <= gram_mem[gram_raddr];
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         hash_mem[hwr_idx] <= hash_wdata;
      end
      hash_q_ff <= hash_mem[hash_raddr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fingerprint_hash = rsp_hash_ff;
   assign rsp_gram_position    = rsp_pos_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rhw_checker.sv
// Port-level checker for the rolling-hash winnowing unit, bound to the top level.
// Uses rhw_pkg types; sees the top-level ports only.
`default_nettype none

module rhw_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input rhw_pkg::char_type      req_char_in,
   input wire                    req_doc_start,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input rhw_pkg::hash_type      rsp_fingerprint_hash,
   input rhw_pkg::pos_type       rsp_gram_position
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fingerprint_hash)
                                 && $stable(rsp_gram_position))
      else $error("stalled result changed or dropped");

   // a stalled request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_char_in)
                                 && $stable(req_doc_start))
      else $error("stalled request changed or dropped");

   // leaving reset the unit is idle with no result pending
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_stall && !rsp_valid)
      else $error("unit not idle after reset");

   // a new result is produced only while a byte is being worked on
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // no byte reaches the result register in the cycle after its transfer
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result too early after request transfer");

endmodule

bind rolling_hash_winnowing_unit rhw_checker u_rhw_checker (.*);

`default_nettype wire

FILE: bench/rolling_hash_winnowing_unit_tb.sv
// Self-checking bench for the rolling-hash winnowing unit: predicts each fingerprint
// from the accepted bytes and compares the result stream. Depends on rhw_pkg and
// rolling_hash_winnowing_unit.
`timescale 1ns / 1ps

module rolling_hash_winnowing_unit_tb;
   import rhw_pkg::*;

   typedef struct packed {
      hash_type hash;
      pos_type  pos;
   } fingerprint_type;

   typedef struct packed {
      char_type value;
      logic     start;
   } doc_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_stall;
   char_type      req_char_in = '0;
   logic          req_doc_start = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   hash_type      rsp_fingerprint_hash;
   pos_type       rsp_gram_position;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_GRAM_LENGTH;
   csr_data_type  csr_wdata = '0;

   rolling_hash_winnowing_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_in(req_char_in),
      .req_doc_start(req_doc_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_fingerprint_hash(rsp_fingerprint_hash),
      .rsp_gram_position(rsp_gram_position),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: register copies and the unit's document state.
   logic [5:0]  cfg_gram_len = RST_GRAM_LENGTH;
   logic [7:0]  cfg_base     = RST_HASH_BASE;
   logic [5:0]  cfg_window   = RST_WINDOW_SIZE;
   logic [30:0] cfg_weight   = RST_LEADING_WEIGHT;
   char_type    byte_ring [32];
   hash_type    hash_ring [32];
   hash_type    roll_hash = '0;
   int unsigned doc_bytes = 0;
   hash_type    sel_hash = '0;
   int unsigned sel_pos = 0;
   logic        sel_valid = 1'b0;

   doc_byte_type    byte_queue [$];
   fingerprint_type expected_prints [$];
   doc_byte_type    staged;
   fingerprint_type want;

   logic calm = 1'b0;
   int   holdoff_left = 0;
   logic holdoff_done = 1'b0;
   int   errors = 0;
   int   bytes_sent = 0;
   int   prints_checked = 0;
   int   doc_count = 0;
   int   setting_count = 0;

   // k, base, w, weight source (0 proper, 1 all ones, 2 random), byte budget
   int phase_plan [12][5] = '{
      '{10, 19, 15, 0, 110}, '{1, 2, 1, 0, 70}, '{32, 255, 32, 0, 150},
      '{0, 7, 0, 0, 60}, '{63, 131, 63, 0, 150}, '{3, 1, 4, 0, 80},
      '{2, 0, 2, 0, 70}, '{16, 31, 8, 2, 90}, '{7, 2, 32, 0, 100},
      '{32, 2, 1, 1, 90}, '{1, 200, 32, 0, 90}, '{5, 97, 3, 0, 90}
   };

   function automatic hash_type residue(input logic [63:0] d);
      return hash_type'(d % {33'd0, PRIME_P});
   endfunction

   function automatic int unsigned effective_len(input logic [5:0] v);
      if (v == 6'd0) return 1;
      return (v > 6'd32) ? 32 : int'(v);
   endfunction

   function automatic hash_type base_power(input logic [7:0] b, input int unsigned e);
      hash_type r;
      r = 31'd1;
      for (int i = 0; i < e; i++) r = residue(64'(r) * b);
      return r;
   endfunction

   // Roll one byte through the hash and the winnowing window; queue any fingerprint.
   function automatic void take_byte(input char_type c, input logic start);
      int unsigned k, w, n, g, j, best_pos;
      hash_type h, best, lead, diff;
      fingerprint_type fp;
      k = effective_len(cfg_gram_len);
      w = effective_len(cfg_window);
      if (start) begin
         doc_bytes = 0;
         roll_hash = '0;
         sel_hash = '0;
         sel_pos = 0;
         sel_valid = 1'b0;
      end
      if (doc_bytes >= POS_MAX) return;
      n = doc_bytes;
      if (n < k) begin
         h = residue(64'(roll_hash) * cfg_base + c);
      end else begin
         lead = residue(64'(byte_ring[(n - k) % 32]) * residue(64'(cfg_weight)));
         diff = residue(64'(roll_hash) + 64'(PRIME_P) - lead);
         h = residue(64'(diff) * cfg_base + c);
      end
      byte_ring[n % 32] = c;
      roll_hash = h;
      doc_bytes = n + 1;
      if (n + 1 < k) return;
      g = n + 1 - k;
      hash_ring[g % 32] = h;
      if (g + 1 < w) return;
      if (!sel_valid || sel_pos + w <= g) begin
         // rescan the whole window, rightmost tie wins
         best_pos = g - w + 1;
         best = hash_ring[best_pos % 32];
         for (j = g - w + 2; j <= g; j++) begin
            if (hash_ring[j % 32] <= best) begin
               best = hash_ring[j % 32];
               best_pos = j;
            end
         end
         sel_hash = best;
         sel_pos = best_pos;
         sel_valid = 1'b1;
      end else if (h <= sel_hash) begin
         sel_hash = h;
         sel_pos = g;
      end else begin
         return;
      end
      fp.hash = sel_hash;
      fp.pos = pos_type'(sel_pos);
      expected_prints.insert(expected_prints.size(), fp);
   endfunction

   function automatic char_type pick_byte(input int style, input int idx, input char_type seed);
      case (style)
         0: return char_type'($urandom_range(0, 255));
         1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         2: return seed;
         3: return seed + char_type'(idx);
         default: return seed - char_type'(idx);
      endcase
   endfunction

   // Driver: offer queued bytes, hold a stalled transfer, predict on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            take_byte(req_char_in, req_doc_start);
            bytes_sent++;
         end
         if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
            staged = byte_queue.pop_front();
            req_valid <= 1'b1;
            req_char_in <= staged.value;
            req_doc_start <= staged.start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result transfer against the oldest expected fingerprint.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_prints.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual hash %h pos %h",
                        $time, rsp_fingerprint_hash, rsp_gram_position);
            end else begin
               want = expected_prints.pop_front();
               if (rsp_fingerprint_hash !== want.hash) begin
                  errors++;
                  $display("%0t: fingerprint hash expected %h actual %h",
                           $time, want.hash, rsp_fingerprint_hash);
               end
               if (rsp_gram_position !== want.pos) begin
                  errors++;
                  $display("%0t: gram position expected %h actual %h",
                           $time, want.pos, rsp_gram_position);
               end
               prints_checked++;
            end
         end
         // one long hold-off so the unit backs up into its input
         if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            rsp_stall <= 1'b1;
         end else if (!holdoff_done && prints_checked >= 60) begin
            holdoff_left <= 300;
            holdoff_done <= 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 15);
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [30:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GRAM_LENGTH:    cfg_gram_len = value[5:0];
         CSR_HASH_BASE:      cfg_base = value[7:0];
         CSR_WINDOW_SIZE:    cfg_window = value[5:0];
         CSR_LEADING_WEIGHT: cfg_weight = value;
         default: ;
      endcase
   endtask

   task automatic program_unit(input int k, input int b, input int w, input int weight_src);
      logic [30:0] weight;
      weight = base_power(8'(b), effective_len(6'(k)) - 1);
      if (weight_src == 1) weight = 31'h7FFF_FFFF;
      if (weight_src == 2) weight = 31'($urandom());
      write_csr(CSR_WINDOW_SIZE, 31'(w));
      write_csr(CSR_HASH_BASE, 31'(b));
      write_csr(CSR_GRAM_LENGTH, 31'(k));
      write_csr(CSR_LEADING_WEIGHT, weight);
      setting_count++;
      @(negedge clock);
   endtask

   task automatic push_byte(input int value, input logic start);
      byte_queue.insert(byte_queue.size(), doc_byte_type'{char_type'(value), start});
      if (start) doc_count++;
   endtask

   task automatic queue_document(input int len, input int style);
      char_type seed;
      seed = char_type'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) push_byte(pick_byte(style, i, seed), i == 0);
   endtask

   // Let every byte go through, collect its fingerprints, then let the pipe settle.
   task automatic drain();
      int waited;
      waited = 0;
      while (byte_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_prints.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_prints.size() != 0) begin
         errors++;
         $display("%0t: %0d fingerprints missing, expected hash %h pos %h, actual none",
                  $time, expected_prints.size(), expected_prints[0].hash,
                  expected_prints[0].pos);
         expected_prints.delete();
      end
      repeat (64) @(posedge clock);
   endtask

   initial begin
      int left, span, len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // k = w = 1: every byte is a fingerprint; first byte needs no document start
      program_unit(1, 2, 1, 0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h80, 1'b1);
      push_byte(8'h01, 1'b0);
      drain();

      // short document, ties, minimum leaving the window, new lower minimum
      program_unit(2, 255, 3, 0);
      push_byte(7, 1'b1);
      push_byte(7, 1'b0);
      push_byte(7, 1'b0);
      push_byte(9, 1'b1);
      for (int i = 0; i < 3; i++) push_byte(9, 1'b0);
      push_byte(200, 1'b0);
      push_byte(150, 1'b0);
      push_byte(100, 1'b0);
      push_byte(3, 1'b0);
      push_byte(1, 1'b0);
      push_byte(0, 1'b0);
      push_byte(0, 1'b0);
      drain();

      for (int p = 0; p < 12; p++) begin
         program_unit(phase_plan[p][0], phase_plan[p][1], phase_plan[p][2],
                      phase_plan[p][3]);
         calm <= (p == 5);
         span = effective_len(cfg_gram_len) + effective_len(cfg_window) - 1;
         left = phase_plan[p][4];
         while (left > 0) begin
            if ($urandom_range(99) < 15) len = $urandom_range(1, span);
            else len = $urandom_range(span, span + 40);
            if (len > left) len = left;
            queue_document(len, $urandom_range(0, 4));
            left -= len;
         end
         drain();
      end

      $display("Covered %0d bytes in %0d documents under %0d register settings,",
               bytes_sent, doc_count, setting_count);
      $display("%0d fingerprints checked; gram and window lengths from zero past the limit,",
               prints_checked);
      $display("bases 0..255 and one long output hold-off.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/rhw_pkg.sv
rtl/core/rolling_hash_winnowing_unit.sv
rtl/core/rhw_checker.sv
bench/rolling_hash_winnowing_unit_tb.sv
